FILE: rtl/timeout_slot_pool_core_defines.svh
// Assertion helpers used by the timeout slot pool RTL.
`ifndef TIMEOUT_SLOT_POOL_CORE_DEFINES_SVH
`define TIMEOUT_SLOT_POOL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timeout slot pool check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timeout slot pool check failed");

`endif

FILE: rtl/tsp_pkg.sv
`timescale 1ns / 1ps
package tsp_pkg;

    // Pool geometry and fixed durations
    localparam int SLOT_COUNT      = 16;
    localparam int SLOT_W          = $clog2(SLOT_COUNT);
    localparam int KNOWN_TYPES     = 9;
    localparam int REG_COUNT       = 8;
    localparam int REG_IDX_W       = $clog2(REG_COUNT);
    localparam int CLI_TYPE        = 8;
    localparam logic [31:0] CLI_DURATION_MS = 32'd1000;
    localparam logic [31:0] FALLBACK_MS     = 32'd1000;
    localparam logic [31:0] STD_RESET_MS    = 32'd1000;
    localparam int COUNT_W         = 5;

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 80;

    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_START_STD    = 3'd1,
        CMD_START_CUSTOM = 3'd2,
        CMD_CHECK        = 3'd3,
        CMD_STOP         = 3'd4,
        CMD_QUERY        = 3'd5,
        CMD_RESET_ALL    = 3'd6
    } cmd_t;

    // One slot record in the slot memory
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] duration;
        logic [31:0] start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/tsp_ram.sv
`timescale 1ns / 1ps
module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/timeout_slot_pool_core.sv
`timescale 1ns / 1ps
// Timeout slot pool: sixteen timeout slots plus a millisecond counter advanced
// by tick commands, driven by one command per input transfer (tick, start
// standard, start custom, check, stop, query, reset all) and answering each
// command with exactly one result transfer. A command first reads the addressed
// slot record (start time, duration, type) from the single-port-read slot memory,
// then computes elapsed and remaining time and writes back state. The block takes
// no new command until the current one has executed; a result waiting in the
// output register stalls only the command behind it, never the result. Active
// and expired marks and the live count sit in flip-flops cleared by reset, so
// the slot memory needs no clearing pass. The user must write the standard
// durations for types 0 to 7 through cfg_* only while idle; the block does not enforce this.
module timeout_slot_pool_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cfg_wdata holds the standard duration in ms for type cfg_index
    input  logic                            cfg_we,
    input  logic [tsp_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: timer_type[3:0], custom_duration[35:4], slot_index[39:36]
    input  logic [tsp_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: command[2:0]
    input  logic [tsp_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: granted_slot[3:0], ok[4], expired_now[5], latched_expired[6],
    //          elapsed_ms[38:7], remaining_ms[70:39], active_count[75:71]
    output logic [tsp_pkg::M_TDATA_W-1:0]   m_tdata
);

    import tsp_pkg::*;

    `include "timeout_slot_pool_core_defines.svh"

    // Control state
    logic                   busy_reg, busy_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [31:0]            now_reg, now_next;
    logic [SLOT_COUNT-1:0]  active_reg, active_next;
    logic [SLOT_COUNT-1:0]  expired_reg, expired_next;
    logic [COUNT_W-1:0]     live_reg, live_next;
    logic [31:0]            std_reg [REG_COUNT];

    // Command held for the execute cycle
    cmd_t                   cmd_reg;
    logic [3:0]             type_reg;
    logic [31:0]            custom_reg;
    logic [3:0]             idx_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Slot memory ports
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    entry_t                 ram_wentry;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    entry_t                 rd_entry;

    logic                   accept;
    logic                   exec;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic [31:0]            std_dur;
    logic [31:0]            start_dur;
    logic                   idx_ok;
    logic [SLOT_W-1:0]      idx_sel;

    // Result fields
    logic [3:0]             granted;
    logic                   ok;
    logic                   exp_now;
    logic                   latched;
    logic [31:0]            elapsed;
    logic [31:0]            remaining;

    // Check helpers
    logic [COUNT_W-1:0]     active_pop;
    logic                   result_stall;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign exec     = busy_reg && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign rd_entry = entry_t'(ram_rdata);
    assign idx_sel  = idx_reg[SLOT_W-1:0];
    assign idx_ok   = int'(idx_reg) < SLOT_COUNT;

    // Read at the arriving index, then keep re-reading while the result stalls
    assign ram_raddr = busy_reg ? idx_reg[SLOT_W-1:0] : s_tdata[36 +: SLOT_W];

    tsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wentry),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Find the lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Pick the standard duration for the type
    always_comb begin
        std_dur = FALLBACK_MS;
        if (int'(type_reg) < KNOWN_TYPES) begin
            if (int'(type_reg) < REG_COUNT) begin
                std_dur = std_reg[type_reg[REG_IDX_W-1:0]];
            end else if (int'(type_reg) == CLI_TYPE) begin
                std_dur = CLI_DURATION_MS;
            end
        end
    end

    assign start_dur = (cmd_reg == CMD_START_CUSTOM) ? custom_reg : std_dur;

    // Execute the held command against the slot record
    always_comb begin
        now_next     = now_reg;
        active_next  = active_reg;
        expired_next = expired_reg;
        live_next    = live_reg;
        ram_we       = 1'b0;
        ram_waddr    = free_slot;
        ram_wentry   = '{kind: type_reg, duration: start_dur, start: now_reg};
        granted      = '0;
        ok           = 1'b0;
        exp_now      = 1'b0;
        latched      = 1'b0;
        elapsed      = '0;
        remaining    = '0;
        if (exec) begin
            unique case (cmd_reg) inside
                CMD_TICK: begin
                    now_next = now_reg + 32'd1;
                end
                CMD_START_STD, CMD_START_CUSTOM: begin
                    if (free_found) begin
                        ram_we                  = 1'b1;
                        active_next[free_slot]  = 1'b1;
                        expired_next[free_slot] = 1'b0;
                        live_next               = live_reg + COUNT_W'(1);
                        granted                 = 4'(free_slot);
                        ok                      = 1'b1;
                        remaining               = start_dur;
                    end
                end
                CMD_CHECK, CMD_STOP, CMD_QUERY: begin
                    if (idx_ok) begin
                        if (active_reg[idx_sel]) begin
                            ok      = 1'b1;
                            elapsed = now_reg - rd_entry.start;
                            if (cmd_reg == CMD_CHECK && elapsed >= rd_entry.duration) begin
                                expired_next[idx_sel] = 1'b1;
                                exp_now               = 1'b1;
                            end
                            if (cmd_reg == CMD_STOP) begin
                                active_next[idx_sel] = 1'b0;
                                if (live_reg != '0) begin
                                    live_next = live_reg - COUNT_W'(1);
                                end
                                elapsed = '0;
                            end else if (elapsed < rd_entry.duration) begin
                                remaining = rd_entry.duration - elapsed;
                            end
                        end
                        latched = expired_next[idx_sel];
                    end
                end
                CMD_RESET_ALL: begin
                    active_next = '0;
                    live_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tdata_next = {4'b0, live_next, remaining, elapsed, latched, exp_now, ok, granted};

    // Advance the handshake
    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (exec) begin
            busy_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (exec) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            now_reg      <= '0;
            active_reg   <= '0;
            expired_reg  <= '0;
            live_reg     <= '0;
            for (int i = 0; i < REG_COUNT; i++) begin
                std_reg[i] <= STD_RESET_MS;
            end
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            now_reg      <= now_next;
            active_reg   <= active_next;
            expired_reg  <= expired_next;
            live_reg     <= live_next;
            if (cfg_we) begin
                std_reg[cfg_index] <= cfg_wdata;
            end
        end
    end

    // Capture the command and the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= cmd_t'(s_tuser);
            type_reg   <= s_tdata[3:0];
            custom_reg <= s_tdata[35:4];
            idx_reg    <= s_tdata[39:36];
        end
        if (exec) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Checks
    assign active_pop   = COUNT_W'($countones(active_reg));
    assign result_stall = busy_reg && m_tvalid_reg && !m_tready;

    `TSP_ASSERT_NOW(a_live_matches_active, aclk, aresetn, 1'b1, live_reg == active_pop)
    `TSP_ASSERT_NEXT(a_accept_enters_exec, aclk, aresetn, accept, busy_reg)
    `TSP_ASSERT_NEXT(a_stall_holds_exec, aclk, aresetn, result_stall, busy_reg && $stable(cmd_reg))
    `TSP_ASSERT_NEXT(a_exec_gives_result, aclk, aresetn, exec, m_tvalid_reg && !busy_reg)

endmodule
